@@ hdl/ght_pkg.sv @@
// ----------------------------------------------------------------------------
// ght_pkg
// Types and constants shared by the generational handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int IDX_W       = 8;   // slot and dense index
  localparam int GEN_W       = 16;  // handle generation
  localparam int CNT_W       = 9;   // counts up to MAX_ENTRIES

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_LOOKUP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STALE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LINK,
    S_EXEC,
    S_MOVE
  } state_t;

  // Slot memory word: generation and dense position. For a free slot the
  // dense field holds the next free slot (free list link).
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [IDX_W-1:0] dense;
  } slot_word_t;

endpackage

@@ hdl/ght_ram.sv @@
// ----------------------------------------------------------------------------
// ght_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/generational_handle_table.sv @@
// ----------------------------------------------------------------------------
// generational_handle_table
// Slot map handing out generation-checked handles over a dense entry array.
// ----------------------------------------------------------------------------
// One request is in work at a time. The slot entry and the last dense entry
// are read at acceptance, the handle's dense entry in the next cycle, and the
// request executes in the cycle after that, so its result is written into the
// output register at the end of execute. A destroy that moves another entry
// into the hole holds the input through a move state, because the slot memory
// has one write port and both the freed slot and the moved slot are written.
// The next request is taken once the block is idle and the output register
// is empty or being read. Free slots are kept as a LIFO linked list through
// the slot memory, so no memory needs clearing after reset.
module generational_handle_table (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [1:0]              in_op,
  input  logic [ght_pkg::IDX_W-1:0] in_slot,
  input  logic [ght_pkg::GEN_W-1:0] in_generation,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [1:0]              out_status,
  output logic [ght_pkg::IDX_W-1:0] out_handle_slot,
  output logic [ght_pkg::GEN_W-1:0] out_handle_generation,
  output logic [ght_pkg::IDX_W-1:0] out_dense_index,
  output logic [ght_pkg::CNT_W-1:0] out_live_count
);

  import ght_pkg::*;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);
  localparam int SW_W = GEN_W + IDX_W;

  state_t state_r, state_nxt;
  op_t    op_r;
  logic [IDX_W-1:0] slot_r;
  logic [GEN_W-1:0] gen_r;
  logic [CNT_W-1:0] live_r, live_nxt;
  logic [CNT_W-1:0] opened_r, opened_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  slot_word_t       sword_r;
  logic [IDX_W-1:0] last_slot_r;
  logic [GEN_W-1:0] mgen_r;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_slot_r, out_slot_nxt;
  logic [GEN_W-1:0] out_gen_r, out_gen_nxt;
  logic [IDX_W-1:0] out_dense_r, out_dense_nxt;
  logic [CNT_W-1:0] out_live_r, out_live_nxt;

  logic             accept;
  logic             hit;
  logic             move_needed;

  logic             s_we;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  slot_word_t       s_wdata, s_rdata;
  logic [SW_W-1:0]  s_rdata_raw;
  logic             d_we;
  logic [IDX_W-1:0] d_waddr, d_wdata, d_raddr, d_rdata;

  ght_ram #(.WIDTH(SW_W), .DEPTH(MAX_ENTRIES)) u_slot_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata_raw)
  );

  assign s_rdata = slot_word_t'(s_rdata_raw);

  ght_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ENTRIES)) u_dense_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // In execute, d_rdata is dense_to_slot at the handle's dense position.
  assign hit = ({1'b0, slot_r} < opened_r) &&
               ({1'b0, sword_r.dense} < live_r) &&
               (d_rdata == slot_r) &&
               (sword_r.gen == gen_r);
  assign move_needed = (op_r == OP_DESTROY) && hit && (last_slot_r != slot_r);

  // Read addresses: slot entry and last dense entry at accept, then the
  // dense entry of the handle and the slot of the entry that would move.
  always_comb begin
    if (state_r == S_LINK) begin
      s_raddr = d_rdata;
      d_raddr = s_rdata.dense;
    end else begin
      s_raddr = (op_t'(in_op) == OP_CREATE) ? head_r : in_slot;
      d_raddr = IDX_W'(live_r - CNT_W'(1));
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_LINK;
      end
      S_LINK: state_nxt = S_EXEC;
      S_EXEC: state_nxt = move_needed ? S_MOVE : S_IDLE;
      S_MOVE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    live_nxt      = live_r;
    opened_nxt    = opened_r;
    free_cnt_nxt  = free_cnt_r;
    head_nxt      = head_r;
    s_we          = 1'b0;
    s_waddr       = slot_r;
    s_wdata       = sword_r;
    d_we          = 1'b0;
    d_waddr       = sword_r.dense;
    d_wdata       = last_slot_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_slot_nxt  = out_slot_r;
    out_gen_nxt   = out_gen_r;
    out_dense_nxt = out_dense_r;
    out_live_nxt  = out_live_r;

    case (state_r)
      S_EXEC: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_STALE;
        out_slot_nxt   = slot_r;
        out_gen_nxt    = gen_r;
        out_dense_nxt  = '0;
        case (op_r)
          OP_CREATE: begin
            if (live_r == FULL_CNT) begin
              out_status_nxt = ST_FULL;
            end else if (free_cnt_r != '0) begin
              // pop the free list head, keep its generation
              s_we           = 1'b1;
              s_waddr        = head_r;
              s_wdata.gen    = sword_r.gen;
              s_wdata.dense  = live_r[IDX_W-1:0];
              d_we           = 1'b1;
              d_waddr        = live_r[IDX_W-1:0];
              d_wdata        = head_r;
              head_nxt       = sword_r.dense;
              free_cnt_nxt   = free_cnt_r - CNT_W'(1);
              live_nxt       = live_r + CNT_W'(1);
              out_status_nxt = ST_OK;
              out_slot_nxt   = head_r;
              out_gen_nxt    = sword_r.gen;
              out_dense_nxt  = live_r[IDX_W-1:0];
            end else if (opened_r != FULL_CNT) begin
              // open a fresh slot at generation zero
              s_we           = 1'b1;
              s_waddr        = opened_r[IDX_W-1:0];
              s_wdata.gen    = '0;
              s_wdata.dense  = live_r[IDX_W-1:0];
              d_we           = 1'b1;
              d_waddr        = live_r[IDX_W-1:0];
              d_wdata        = opened_r[IDX_W-1:0];
              opened_nxt     = opened_r + CNT_W'(1);
              live_nxt       = live_r + CNT_W'(1);
              out_status_nxt = ST_OK;
              out_slot_nxt   = opened_r[IDX_W-1:0];
              out_gen_nxt    = '0;
              out_dense_nxt  = live_r[IDX_W-1:0];
            end else begin
              out_status_nxt = ST_FULL;
            end
          end
          OP_DESTROY: begin
            if (hit) begin
              // swap-remove, bump generation, push slot on the free list
              d_we           = 1'b1;
              d_waddr        = sword_r.dense;
              d_wdata        = last_slot_r;
              s_we           = 1'b1;
              s_waddr        = slot_r;
              s_wdata.gen    = sword_r.gen + GEN_W'(1);
              s_wdata.dense  = head_r;
              head_nxt       = slot_r;
              free_cnt_nxt   = free_cnt_r + CNT_W'(1);
              live_nxt       = live_r - CNT_W'(1);
              out_status_nxt = ST_OK;
            end
          end
          OP_LOOKUP: begin
            if (hit) begin
              out_status_nxt = ST_OK;
              out_dense_nxt  = sword_r.dense;
            end
          end
          default: begin
            out_status_nxt = ST_STALE;
          end
        endcase
        out_live_nxt = live_nxt;
      end
      S_MOVE: begin
        // retarget the moved entry's slot to the hole
        s_we          = 1'b1;
        s_waddr       = last_slot_r;
        s_wdata.gen   = mgen_r;
        s_wdata.dense = sword_r.dense;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      live_r      <= '0;
      opened_r    <= '0;
      free_cnt_r  <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      live_r      <= live_nxt;
      opened_r    <= opened_nxt;
      free_cnt_r  <= free_cnt_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_gen_r    <= out_gen_nxt;
    out_dense_r  <= out_dense_nxt;
    out_live_r   <= out_live_nxt;
    if (accept) begin
      op_r   <= op_t'(in_op);
      slot_r <= in_slot;
      gen_r  <= in_generation;
    end
    if (state_r == S_LINK) begin
      sword_r     <= s_rdata;
      last_slot_r <= d_rdata;
    end
    if (state_r == S_EXEC) begin
      mgen_r <= s_rdata.gen;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_handle_slot       = out_slot_r;
  assign out_handle_generation = out_gen_r;
  assign out_dense_index       = out_dense_r;
  assign out_live_count        = out_live_r;

endmodule

@@ hdl/ght_chk.sv @@
// ----------------------------------------------------------------------------
// ght_chk
// Port-level checks for the generational handle table, bound to the top.
// ----------------------------------------------------------------------------
module ght_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                out_status,
  input logic [ght_pkg::IDX_W-1:0] out_handle_slot,
  input logic [ght_pkg::GEN_W-1:0] out_handle_generation,
  input logic [ght_pkg::IDX_W-1:0] out_dense_index,
  input logic [ght_pkg::CNT_W-1:0] out_live_count
);

  import ght_pkg::*;

  // one request in work: stall right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while another was in work");

  // full only when every entry is live
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FULL |-> out_live_count == CNT_W'(MAX_ENTRIES))
    else $error("table full reported below capacity");

  // a nonzero returned dense position lies inside the live range
  a_dense_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OK && out_dense_index != '0
      |-> {1'b0, out_dense_index} < out_live_count)
    else $error("dense index beyond live count");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_handle_slot) && $stable(out_handle_generation) &&
      $stable(out_dense_index) && $stable(out_live_count))
    else $error("stalled result changed");

endmodule

bind generational_handle_table ght_chk u_ght_chk (.*);
